[hdl/oads_pkg.sv]
// Package for the ordered array block: mode and status codes, plus the
// command and status structs between the controller and the datapath.
// No dependencies.
`default_nettype none

package oads_pkg;

  // Widths of counts and positions, data words and status codes on the ports
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned STAT_W = 3;

  // Item modes
  localparam logic [1:0] MODE_INSERT   = 2'd0;
  localparam logic [1:0] MODE_DELETE   = 2'd1;
  localparam logic [1:0] MODE_SEARCH   = 2'd2;
  localparam logic [1:0] MODE_TRAVERSE = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  // What the result register takes its word and position from
  typedef enum logic [1:0] {
    EMIT_PLAIN = 2'd0,
    EMIT_FIND  = 2'd1,
    EMIT_TRAV  = 2'd2
  } emit_kind_e;

  // Controller to datapath
  typedef struct packed {
    logic              load_op;
    logic              shift_ins;
    logic              shift_del;
    logic              cap_match;
    logic              rotate;
    logic              emit;
    emit_kind_e        kind;
    logic [STAT_W-1:0] status;
    logic              last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic bad_ins;
    logic bad_del;
    logic hit;
    logic trav_last;
  } sts_t;

endpackage

`default_nettype wire

[hdl/oads_datapath.sv]
// Datapath of the ordered array: a row of word cells that shift, rotate and
// compare in place, the fill count, operand latches and result registers.
// Depends on oads_pkg.
`default_nettype none

module oads_datapath import oads_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cmd_t                     cmd_i,
  output sts_t                          sts_o,
  input  wire logic signed [WORD_W-1:0] data_word_i,
  input  wire logic        [CNT_W-1:0]  slot_pos_i,
  output logic                          result_valid_o,
  output logic             [STAT_W-1:0] status_o,
  output logic signed      [WORD_W-1:0] read_word_o,
  output logic             [CNT_W-1:0]  found_pos_o,
  output logic             [CNT_W-1:0]  fill_after_o,
  output logic                          last_item_o
);

  // Cell row and fill count
  logic [WORD_W-1:0] cells_q [DEPTH];
  logic [WORD_W-1:0] cells_d [DEPTH];
  logic [CNT_W-1:0]  fill_q, fill_d;

  // Operand latches
  logic [WORD_W-1:0] word_q;
  logic [CNT_W-1:0]  pos_q;

  // Search match vector and traverse index
  logic [DEPTH-1:0]  match_q;
  logic [CNT_W-1:0]  trav_idx_q, trav_idx_d;

  // Result registers
  logic              valid_q;
  logic [STAT_W-1:0] status_q;
  logic [WORD_W-1:0] word_out_q;
  logic [CNT_W-1:0]  pos_out_q;
  logic [CNT_W-1:0]  fill_out_q;
  logic              last_q;

  logic [CNT_W-1:0]  find_pos;
  logic [CNT_W:0]    fill_p1;
  logic [CNT_W-1:0]  trav_pos;

  // Status towards the controller
  assign fill_p1  = {1'b0, fill_q} + {{CNT_W{1'b0}}, 1'b1};
  assign trav_pos = trav_idx_q + {{(CNT_W-1){1'b0}}, 1'b1};

  always_comb begin
    sts_o.full      = (fill_q == CNT_W'(DEPTH));
    sts_o.empty     = (fill_q == '0);
    sts_o.bad_ins   = (pos_q == '0) || ({1'b0, pos_q} > fill_p1);
    sts_o.bad_del   = (pos_q == '0) || (pos_q > fill_q);
    sts_o.hit       = |match_q;
    sts_o.trav_last = (trav_pos == fill_q);
  end

  // First matching cell, as a 1-based position
  always_comb begin
    find_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        find_pos = CNT_W'(i + 1);
      end
    end
  end

  // Next value of each cell: insert, delete or rotate, each cell on its own
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cells_d[i] = cells_q[i];
      if (cmd_i.shift_ins) begin
        if (CNT_W'(i + 1) == pos_q) begin
          cells_d[i] = word_q;
        end else if ((CNT_W'(i + 1) > pos_q) && (CNT_W'(i) <= fill_q) && (i > 0)) begin
          cells_d[i] = cells_q[i-1];
        end
      end else if (cmd_i.shift_del) begin
        if ((CNT_W'(i + 1) >= pos_q) && (CNT_W'(i + 1) < fill_q) && (i < DEPTH - 1)) begin
          cells_d[i] = cells_q[i+1];
        end
      end else if (cmd_i.rotate) begin
        if (CNT_W'(i + 1) == fill_q) begin
          cells_d[i] = cells_q[0];
        end else if ((CNT_W'(i + 1) < fill_q) && (i < DEPTH - 1)) begin
          cells_d[i] = cells_q[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      cells_q[i] <= cells_d[i];
    end
  end

  // Fill count
  always_comb begin
    fill_d = fill_q;
    if (cmd_i.shift_ins) begin
      fill_d = fill_q + {{(CNT_W-1){1'b0}}, 1'b1};
    end else if (cmd_i.shift_del) begin
      fill_d = fill_q - {{(CNT_W-1){1'b0}}, 1'b1};
    end
  end

  // Traverse index
  always_comb begin
    trav_idx_d = trav_idx_q;
    if (cmd_i.load_op) begin
      trav_idx_d = '0;
    end else if (cmd_i.rotate) begin
      trav_idx_d = trav_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      trav_idx_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      trav_idx_q <= trav_idx_d;
      valid_q    <= cmd_i.emit;
    end
  end

  // Operands and match vector
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_op) begin
      word_q <= data_word_i;
      pos_q  <= slot_pos_i;
    end
    if (cmd_i.cap_match) begin
      for (int i = 0; i < DEPTH; i++) begin
        match_q[i] <= (cells_q[i] == word_q) && (CNT_W'(i) < fill_q);
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q   <= cmd_i.status;
      last_q     <= cmd_i.last;
      fill_out_q <= fill_d;
      case (cmd_i.kind)
        EMIT_FIND: begin
          word_out_q <= '0;
          pos_out_q  <= find_pos;
        end
        EMIT_TRAV: begin
          word_out_q <= cells_q[0];
          pos_out_q  <= trav_pos;
        end
        default: begin
          word_out_q <= '0;
          pos_out_q  <= '0;
        end
      endcase
    end
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign read_word_o    = word_out_q;
  assign found_pos_o    = pos_out_q;
  assign fill_after_o   = fill_out_q;
  assign last_item_o    = last_q;

endmodule

`default_nettype wire

[hdl/oads_ctrl.sv]
// Controller of the ordered array: sequences each item and issues commands
// to the datapath from its status.
// Depends on oads_pkg.
`default_nettype none

module oads_ctrl import oads_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  input  wire logic [1:0] mode_i,
  output logic            busy,
  input  wire sts_t       sts_i,
  output cmd_t            cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INS  = 6'b000010,
    S_DEL  = 6'b000100,
    S_CMP  = 6'b001000,
    S_FIND = 6'b010000,
    S_TRAV = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.kind   = EMIT_PLAIN;
    cmd_o.status = ST_OK;
    cmd_o.last   = 1'b1;
    busy    = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load_op = 1'b1;
          case (mode_i)
            MODE_INSERT: state_d = S_INS;
            MODE_DELETE: state_d = S_DEL;
            MODE_SEARCH: state_d = S_CMP;
            default:     state_d = S_TRAV;
          endcase
        end
      end
      S_INS: begin
        cmd_o.emit = 1'b1;
        if (sts_i.full) begin
          cmd_o.status = ST_FULL;
        end else if (sts_i.bad_ins) begin
          cmd_o.status = ST_BADPOS;
        end else begin
          cmd_o.shift_ins = 1'b1;
        end
        state_d = S_IDLE;
      end
      S_DEL: begin
        cmd_o.emit = 1'b1;
        if (sts_i.empty) begin
          cmd_o.status = ST_EMPTY;
        end else if (sts_i.bad_del) begin
          cmd_o.status = ST_BADPOS;
        end else begin
          cmd_o.shift_del = 1'b1;
        end
        state_d = S_IDLE;
      end
      S_CMP: begin
        cmd_o.cap_match = 1'b1;
        state_d = S_FIND;
      end
      S_FIND: begin
        cmd_o.emit   = 1'b1;
        cmd_o.kind   = EMIT_FIND;
        cmd_o.status = sts_i.hit ? ST_OK : ST_NOTFOUND;
        state_d = S_IDLE;
      end
      S_TRAV: begin
        cmd_o.emit = 1'b1;
        if (sts_i.empty) begin
          cmd_o.status = ST_EMPTY;
          state_d = S_IDLE;
        end else begin
          // give the head cell and rotate the row by one
          cmd_o.kind   = EMIT_TRAV;
          cmd_o.rotate = 1'b1;
          cmd_o.last   = sts_i.trav_last;
          if (sts_i.trav_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hdl/ordered_array_insert_delete_search.sv]
// Ordered array with insert, delete, search and traverse: top level joining
// the controller and the datapath. Depends on oads_pkg, oads_ctrl, oads_datapath.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+----------------------------------
//   command   | start, busy               | mode_i, data_word_i, slot_pos_i
//   result    | result_valid_o (strobe)   | status_o, read_word_o, found_pos_o,
//             |                           | fill_after_o, last_item_o
//
// A command is taken when start is high and busy low. Insert and delete
// latch the operands, then shift the cell row; search latches, compares all
// cells, then picks the first match; traverse gives one result per cycle as
// the cell row rotates through its head, or one empty status on an empty list.
// Each result strobes in the cycle after it is formed; the receiver cannot
// stall. Reset empties the list at once; cell contents are not cleared.
`default_nettype none

module ordered_array_insert_delete_search import oads_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic             [1:0]   mode_i,
  input  wire logic signed [WORD_W-1:0] data_word_i,
  input  wire logic        [CNT_W-1:0]  slot_pos_i,
  output logic                          result_valid_o,
  output logic             [STAT_W-1:0] status_o,
  output logic signed      [WORD_W-1:0] read_word_o,
  output logic             [CNT_W-1:0]  found_pos_o,
  output logic             [CNT_W-1:0]  fill_after_o,
  output logic                          last_item_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  oads_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (mode_i),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Cell row and result registers
  oads_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .data_word_i    (data_word_i),
    .slot_pos_i     (slot_pos_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .read_word_o    (read_word_o),
    .found_pos_o    (found_pos_o),
    .fill_after_o   (fill_after_o),
    .last_item_o    (last_item_o)
  );

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for ordered_array_insert_delete_search: directed and random
// insert, delete, search and traverse commands checked against a shadow list.
// Depends on oads_pkg and the ordered_array_insert_delete_search RTL.
`default_nettype none

module testbench;
  import oads_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int          STALL_LIMIT = 1000;
  localparam int          SETTLE      = 8;
  localparam int          MAX_SHOWN   = 10;

  // One result transaction as the block should give it
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] word;
    logic [CNT_W-1:0]         pos;
    logic [CNT_W-1:0]         fill;
    logic                     last;
  } reply_t;

  // Shadow list and queue of replies still owed by the block
  class list_tracker;
    logic signed [WORD_W-1:0] cells[$];
    reply_t                   pending_replies[$];
    int                       faults;

    function void queue_reply(logic [STAT_W-1:0] status, logic signed [WORD_W-1:0] word,
                              logic [CNT_W-1:0] pos, logic last);
      reply_t r;
      r.status = status;
      r.word   = word;
      r.pos    = pos;
      r.fill   = CNT_W'(cells.size());
      r.last   = last;
      pending_replies.push_back(r);
    endfunction

    // Work out the replies to a command taken by the block
    function void note_command(logic [1:0] mode, logic signed [WORD_W-1:0] word,
                               logic [CNT_W-1:0] pos);
      int n;
      n = cells.size();
      case (mode)
        MODE_INSERT: begin
          // fullness is judged before the position
          if (n >= DEPTH) begin
            queue_reply(ST_FULL, '0, '0, 1'b1);
          end else if (pos == 0 || int'(pos) > n + 1) begin
            queue_reply(ST_BADPOS, '0, '0, 1'b1);
          end else begin
            cells.insert(int'(pos) - 1, word);
            queue_reply(ST_OK, '0, '0, 1'b1);
          end
        end
        MODE_DELETE: begin
          if (n == 0) begin
            queue_reply(ST_EMPTY, '0, '0, 1'b1);
          end else if (pos == 0 || int'(pos) > n) begin
            queue_reply(ST_BADPOS, '0, '0, 1'b1);
          end else begin
            cells.delete(int'(pos) - 1);
            queue_reply(ST_OK, '0, '0, 1'b1);
          end
        end
        MODE_SEARCH: begin
          // first equal entry wins
          for (int i = 0; i < n; i++) begin
            if (cells[i] == word) begin
              queue_reply(ST_OK, '0, CNT_W'(i + 1), 1'b1);
              return;
            end
          end
          queue_reply(ST_NOTFOUND, '0, '0, 1'b1);
        end
        default: begin
          if (n == 0) queue_reply(ST_EMPTY, '0, '0, 1'b1);
          for (int i = 0; i < n; i++)
            queue_reply(ST_OK, cells[i], CNT_W'(i + 1), i == n - 1);
        end
      endcase
    endfunction

    function void report_fault(string msg);
      faults++;
      if (faults <= MAX_SHOWN) $display("mismatch: %s", msg);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want)
        report_fault($sformatf("%s expected %0h, got %0h", name, want, got));
    endfunction

    // Compare a result transaction with the oldest reply owed
    function void check_result(logic [STAT_W-1:0] status, logic signed [WORD_W-1:0] word,
                               logic [CNT_W-1:0] pos, logic [CNT_W-1:0] fill, logic last);
      reply_t want;
      if (pending_replies.size() == 0) begin
        report_fault($sformatf("result with none owed: status %0d word %0h pos %0d",
                               status, word, pos));
        return;
      end
      want = pending_replies.pop_front();
      compare_field("status", want.status, status);
      compare_field("read_word", want.word, word);
      compare_field("found_pos", want.pos, pos);
      compare_field("fill_after", want.fill, fill);
      compare_field("last_item", want.last, last);
    endfunction
  endclass

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     start       = 1'b0;
  logic               [1:0] mode_i      = MODE_INSERT;
  logic signed [WORD_W-1:0] data_word_i = '0;
  logic        [CNT_W-1:0]  slot_pos_i  = '0;
  logic                     busy;
  logic                     result_valid_o;
  logic        [STAT_W-1:0] status_o;
  logic signed [WORD_W-1:0] read_word_o;
  logic        [CNT_W-1:0]  found_pos_o;
  logic        [CNT_W-1:0]  fill_after_o;
  logic                     last_item_o;

  list_tracker tracker;
  int          idle_cycles = 0;
  int          calm_left   = 0;

  always #10 clk_i = ~clk_i;

  ordered_array_insert_delete_search #(.DEPTH(DEPTH)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .data_word_i    (data_word_i),
    .slot_pos_i     (slot_pos_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .read_word_o    (read_word_o),
    .found_pos_o    (found_pos_o),
    .fill_after_o   (fill_after_o),
    .last_item_o    (last_item_o)
  );

  // Result monitor and stall counter
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o)
        tracker.check_result(status_o, read_word_o, found_pos_o, fill_after_o, last_item_o);
      if ((start && !busy) || result_valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog
  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Gap between commands: mostly short, now and then long, with calm stretches
  function automatic int gap_len();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(5, 15);
    r = $urandom_range(0, 99);
    if (r < 35) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Drive one command, wait until it is taken, then idle for a random gap, which may be none
  task automatic issue(input logic [1:0] mode, input logic signed [WORD_W-1:0] word,
                       input logic [CNT_W-1:0] pos);
    int n;
    mode_i      <= mode;
    data_word_i <= word;
    slot_pos_i  <= pos;
    start       <= 1'b1;
    do @(posedge clk_i); while (busy);
    tracker.note_command(mode, word, pos);
    n = gap_len();
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Extremes, a small pool for duplicates, or anything
  function automatic logic signed [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    if (r < 4) return WORD_W'($urandom_range(0, 7));
    return $urandom;
  endfunction

  // Search keys are mostly taken from the list itself
  function automatic logic signed [WORD_W-1:0] pick_key();
    int n;
    n = tracker.cells.size();
    if (n > 0 && $urandom_range(0, 9) < 6) return tracker.cells[$urandom_range(0, n - 1)];
    return pick_word();
  endfunction

  task automatic random_item(input int ins_pct, input int del_pct, input int srch_pct);
    int                       r;
    int                       lim;
    logic               [1:0] mode;
    logic        [CNT_W-1:0]  pos;
    logic signed [WORD_W-1:0] word;
    r = $urandom_range(0, 99);
    if (r < ins_pct) mode = MODE_INSERT;
    else if (r < ins_pct + del_pct) mode = MODE_DELETE;
    else if (r < ins_pct + del_pct + srch_pct) mode = MODE_SEARCH;
    else mode = MODE_TRAVERSE;
    word = (mode == MODE_SEARCH) ? pick_key() : pick_word();
    lim  = tracker.cells.size() + ((mode == MODE_INSERT) ? 1 : 0);
    // one position in ten is out of range, and every one when the range is empty
    if (lim == 0 || $urandom_range(0, 9) == 0)
      pos = $urandom_range(0, 1) ? CNT_W'(0) : CNT_W'($urandom_range(lim + 1, 127));
    else
      pos = CNT_W'($urandom_range(1, lim));
    issue(mode, word, pos);
  endtask

  initial begin
    tracker = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list, bad positions, extremes, duplicates, end positions
    issue(MODE_TRAVERSE, 0, 0);
    issue(MODE_DELETE, 0, 1);
    issue(MODE_SEARCH, 0, 0);
    issue(MODE_INSERT, 32'sd9, 0);
    issue(MODE_INSERT, 32'sd9, 2);
    issue(MODE_INSERT, 32'sh8000_0000, 1);
    issue(MODE_INSERT, 32'sh7fff_ffff, 2);
    issue(MODE_INSERT, -32'sd1, 1);
    issue(MODE_INSERT, 32'sd9, 127);
    issue(MODE_INSERT, 32'sd0, 2);
    issue(MODE_INSERT, 32'sh7fff_ffff, 5);
    issue(MODE_SEARCH, 32'sh7fff_ffff, 0);
    issue(MODE_SEARCH, 32'sd5, 127);
    issue(MODE_TRAVERSE, -32'sd1, 127);
    issue(MODE_DELETE, 0, 0);
    issue(MODE_DELETE, 0, 6);
    issue(MODE_DELETE, 0, 127);
    issue(MODE_DELETE, 0, 1);
    issue(MODE_DELETE, 0, 4);
    issue(MODE_SEARCH, 32'sh8000_0000, 0);
    issue(MODE_TRAVERSE, 0, 0);

    // Fill the list up with mostly random inserts
    while (tracker.cells.size() < DEPTH) random_item(95, 1, 2);

    // Full list: fullness ahead of position, longest traverse, last slot
    issue(MODE_INSERT, pick_word(), 1);
    issue(MODE_INSERT, pick_word(), 0);
    issue(MODE_INSERT, pick_word(), 127);
    issue(MODE_TRAVERSE, pick_word(), 0);
    issue(MODE_SEARCH, tracker.cells[DEPTH - 1], 0);
    issue(MODE_DELETE, 0, CNT_W'(DEPTH + 1));
    issue(MODE_DELETE, 0, CNT_W'(DEPTH));
    issue(MODE_INSERT, 32'sh7fff_ffff, CNT_W'(DEPTH));
    issue(MODE_SEARCH, $urandom, 0);

    // Mixed traffic, drifting downwards
    repeat (10) random_item(30, 35, 20);

    // Drain and settle
    start <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_replies.size() != 0);
    repeat (SETTLE) @(posedge clk_i);

    if (tracker.faults == 0 && tracker.pending_replies.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hdl/oads_pkg.sv
hdl/oads_datapath.sv
hdl/oads_ctrl.sv
hdl/ordered_array_insert_delete_search.sv
tb/testbench.sv
